/* rtl/bgts_pkg.sv */
// shared types and constants for the bmp gray/threshold stream filter
package bgts_pkg;

   // file layout positions
   localparam int HDR_OFFSET_POS   = 10;
   localparam int HDR_WIDTH_POS    = 14 + 4;
   localparam int HDR_HEIGHT_POS   = 14 + 8;
   localparam int MIN_PIXEL_OFFSET = 26;

   // pixel math: sum / 3 as (sum * 683) >> 11, exact for sums up to 765
   localparam int SUM_BITS   = 10;
   localparam int AVG_RECIP  = 683;
   localparam int AVG_SHIFT  = 11;
   localparam int PROD_BITS  = 20;

   localparam logic [7:0] WHITE = 8'hff;
   localparam logic [7:0] BLACK = 8'h00;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       last_out;
      logic       group_end;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_PIXEL,
      CMD_FLUSH
   } cmd_kind_type;

   // one command from the front end to the back end
   typedef struct packed {
      cmd_kind_type          kind;
      logic [7:0]            data;
      logic [7:0]            held0;
      logic [7:0]            held1;
      logic [1:0]            count;
      logic [SUM_BITS-1:0]   sum;
      logic                  gray;
      logic                  last;
   } cmd_type;

endpackage

/* rtl/bgts_front.sv */
// front end: header capture, pixel tracking and command generation
module bgts_front #(
   parameter int DIM_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  bgts_pkg::req_type req,
   input  logic              gray_mode,
   output logic              cmd_push,
   output bgts_pkg::cmd_type cmd
);

   localparam int RB_BITS = DIM_BITS + 2;
   localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};

   logic [31:0]         pos_ff, pos_in;
   logic [31:0]         offset_ff, offset_in;
   logic [31:0]         scratch_ff, scratch_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [RB_BITS-1:0]  wb_ff, wb_in;
   logic [RB_BITS-1:0]  row_size_ff, row_size_in;
   logic [RB_BITS-1:0]  row_byte_ff, row_byte_in;
   logic [DIM_BITS-1:0] row_cnt_ff, row_cnt_in;
   logic [7:0]          held0_ff, held0_in;
   logic [7:0]          held1_ff, held1_in;
   logic [1:0]          phase_ff, phase_in;

   logic [31:0]         repaired_mag;
   logic [DIM_BITS-1:0] repaired;
   logic [RB_BITS-1:0]  wb_new;
   logic [1:0]          pad_new;
   logic [1:0]          off_lane;
   logic [1:0]          dim_lane;
   logic [31:0]         scratch_new;
   logic                in_pixels;
   logic                pix_byte;
   logic [RB_BITS-1:0]  row_byte_next;

   // header field lanes
   assign off_lane = 2'(pos_ff - 32'(bgts_pkg::HDR_OFFSET_POS));
   assign dim_lane = 2'(pos_ff - 32'(bgts_pkg::HDR_WIDTH_POS));
   assign scratch_new = ((dim_lane == 2'd0) ? 32'd0 : scratch_ff)
                      | (32'(req.byte_in) << {dim_lane, 3'b000});

   // dimension repair: magnitude, then clamp
   assign repaired_mag = scratch_new[31] ? (~scratch_new + 32'd1) : scratch_new;
   assign repaired     = ((repaired_mag >> DIM_BITS) != 32'd0) ? DIM_MAX
                       : repaired_mag[DIM_BITS-1:0];
   assign wb_new       = (RB_BITS'(repaired) << 1) + RB_BITS'(repaired);
   assign pad_new      = 2'd0 - wb_new[1:0];

   // pixel region classification
   assign in_pixels = (pos_ff >= 32'(bgts_pkg::MIN_PIXEL_OFFSET))
                   && (pos_ff >= offset_ff) && (wb_ff != '0)
                   && (row_cnt_ff < height_ff);
   assign pix_byte  = in_pixels && (row_byte_ff < wb_ff);
   assign row_byte_next = row_byte_ff + RB_BITS'(1);

   // next state and command
   always_comb begin
      pos_in      = pos_ff;
      offset_in   = offset_ff;
      scratch_in  = scratch_ff;
      height_in   = height_ff;
      wb_in       = wb_ff;
      row_size_in = row_size_ff;
      row_byte_in = row_byte_ff;
      row_cnt_in  = row_cnt_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      phase_in    = phase_ff;
      cmd_push    = 1'b0;
      cmd.kind    = bgts_pkg::CMD_PASS;
      cmd.data    = req.byte_in;
      cmd.held0   = held0_ff;
      cmd.held1   = held1_ff;
      cmd.count   = phase_ff;
      cmd.sum     = bgts_pkg::SUM_BITS'(held0_ff) + bgts_pkg::SUM_BITS'(held1_ff)
                  + bgts_pkg::SUM_BITS'(req.byte_in);
      cmd.gray    = gray_mode;
      cmd.last    = req.last_in;
      if (accept) begin
         // header capture
         if (pos_ff >= 32'(bgts_pkg::HDR_OFFSET_POS)
             && pos_ff < 32'(bgts_pkg::HDR_OFFSET_POS + 4)) begin
            offset_in = offset_ff | (32'(req.byte_in) << {off_lane, 3'b000});
         end
         if (pos_ff >= 32'(bgts_pkg::HDR_WIDTH_POS)
             && pos_ff < 32'(bgts_pkg::HDR_HEIGHT_POS + 4)) begin
            scratch_in = scratch_new;
            if (pos_ff == 32'(bgts_pkg::HDR_WIDTH_POS + 3)) begin
               wb_in       = wb_new;
               row_size_in = wb_new + RB_BITS'(pad_new);
            end
            if (pos_ff == 32'(bgts_pkg::HDR_HEIGHT_POS + 3)) begin
               height_in = repaired;
            end
         end
         // pixel bytes: hold, release a triple, or flush a short one; other bytes pass through
         if (pix_byte) begin
            if (phase_ff == 2'd2) begin
               cmd_push = 1'b1;
               cmd.kind = bgts_pkg::CMD_PIXEL;
               phase_in = 2'd0;
            end else if (!req.last_in) begin
               if (phase_ff == 2'd0) begin
                  held0_in = req.byte_in;
               end else begin
                  held1_in = req.byte_in;
               end
               phase_in = phase_ff + 2'd1;
            end else begin
               cmd_push = 1'b1;
               cmd.kind = bgts_pkg::CMD_FLUSH;
               phase_in = 2'd0;
            end
         end else begin
            cmd_push = 1'b1;
         end
         // row tracking
         if (in_pixels) begin
            if (row_byte_next >= row_size_ff) begin
               row_byte_in = '0;
               row_cnt_in  = row_cnt_ff + DIM_BITS'(1);
            end else begin
               row_byte_in = row_byte_next;
            end
         end
         // saturating position
         if (pos_ff != 32'hffff_ffff) begin
            pos_in = pos_ff + 32'd1;
         end
         // end of file returns to the start state
         if (req.last_in) begin
            pos_in      = '0;
            offset_in   = '0;
            scratch_in  = '0;
            height_in   = '0;
            wb_in       = '0;
            row_size_in = '0;
            row_byte_in = '0;
            row_cnt_in  = '0;
            phase_in    = '0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         offset_ff   <= '0;
         scratch_ff  <= '0;
         height_ff   <= '0;
         wb_ff       <= '0;
         row_size_ff <= '0;
         row_byte_ff <= '0;
         row_cnt_ff  <= '0;
         phase_ff    <= '0;
      end else begin
         pos_ff      <= pos_in;
         offset_ff   <= offset_in;
         scratch_ff  <= scratch_in;
         height_ff   <= height_in;
         wb_ff       <= wb_in;
         row_size_ff <= row_size_in;
         row_byte_ff <= row_byte_in;
         row_cnt_ff  <= row_cnt_in;
         phase_ff    <= phase_in;
      end
   end

   // held pixel bytes
   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

   // a pending triple never holds more than two bytes
   assert property (@(posedge clock) disable iff (reset) phase_ff != 2'd3)
      else $error("pixel phase out of range");

   // end of file rewinds the position and drops held bytes
   assert property (@(posedge clock) disable iff (reset)
      accept && req.last_in |=> pos_ff == 32'd0 && phase_ff == 2'd0)
      else $error("stream state not cleared after last byte");

   // row byte index stays inside the row
   assert property (@(posedge clock) disable iff (reset)
      wb_ff != '0 |-> row_byte_ff < row_size_ff)
      else $error("row byte index past row size");

endmodule

/* rtl/bgts_cmd_queue.sv */
// small command queue between front end and back end
module bgts_cmd_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bgts_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output bgts_pkg::cmd_type head,
   output logic              empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   bgts_pkg::cmd_type   slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill count never exceeds the queue depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("command queue overfilled");

endmodule

/* rtl/bgts_back.sv */
// back end: expands commands into result bytes through an output register
module bgts_back (
   input  logic              clock,
   input  logic              reset,
   input  bgts_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bgts_pkg::rsp_type rsp_data
);

   logic [1:0]                     idx_ff, idx_in;
   logic                           out_valid_ff, out_valid_in;
   bgts_pkg::rsp_type              out_ff, out_in;
   bgts_pkg::rsp_type              res;
   logic [1:0]                     last_idx;
   logic [bgts_pkg::PROD_BITS-1:0] prod;
   logic [7:0]                     avg;
   logic [7:0]                     pix;
   logic                           load;

   // pixel value: sum / 3, then optional threshold
   assign prod = bgts_pkg::PROD_BITS'(cmd.sum)
               * bgts_pkg::PROD_BITS'(bgts_pkg::AVG_RECIP);
   assign avg  = 8'(prod >> bgts_pkg::AVG_SHIFT);
   assign pix  = cmd.gray ? avg : (avg[7] ? bgts_pkg::WHITE : bgts_pkg::BLACK);

   // result for the current command and slot
   always_comb begin
      res.byte_out  = cmd.data;
      res.last_out  = cmd.last;
      res.group_end = 1'b1;
      last_idx      = 2'd0;
      case (cmd.kind)
         bgts_pkg::CMD_PASS: begin
            last_idx = 2'd0;
         end
         bgts_pkg::CMD_PIXEL: begin
            last_idx      = 2'd2;
            res.byte_out  = pix;
            res.last_out  = cmd.last && (idx_ff == 2'd2);
            res.group_end = (idx_ff == 2'd2);
         end
         bgts_pkg::CMD_FLUSH: begin
            last_idx = cmd.count;
            if (idx_ff != cmd.count) begin
               res.byte_out  = (idx_ff == 2'd0) ? cmd.held0 : cmd.held1;
               res.last_out  = 1'b0;
               res.group_end = 1'b0;
            end
         end
         default: begin
            last_idx = 2'd0;
         end
      endcase
   end

   // load the output register when a command is queued and the register is free or being drained
   assign load    = !cmd_empty && (!out_valid_ff || rsp_pop);
   assign cmd_pop = load && (idx_ff == last_idx);

   always_comb begin
      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (load) begin
         out_in       = res;
         out_valid_in = 1'b1;
         idx_in       = (idx_ff == last_idx) ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // a partly expanded command stays at the queue head
   assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> !cmd_empty)
      else $error("expansion slot set with no command");

   // pass-through commands take exactly one slot
   assert property (@(posedge clock) disable iff (reset)
      !cmd_empty && cmd.kind == bgts_pkg::CMD_PASS |-> idx_ff == 2'd0)
      else $error("pass command expanded past one result");

endmodule

/* rtl/bmp_gray_threshold_stream.sv */
// top level: bmp grayscale / threshold stream filter
// an accepted request's command passes through the command queue, then the output register
// throughput: one request per cycle while req_full is low, and one result per cycle through the
// output register while rsp_pop is high; a short last triple releases up to three results from one request
// reset clears the header capture, row counters, held pixel count, gray_mode and all queues
// the command queue depth (QUEUE_DEPTH) sets how far the input can run ahead of the output
module bmp_gray_threshold_stream #(
   parameter int DIM_BITS    = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bgts_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bgts_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   logic              gray_mode_ff, gray_mode_in;
   logic              accept;
   logic              cmd_push;
   bgts_pkg::cmd_type cmd_in;
   bgts_pkg::cmd_type cmd_head;
   logic              cmd_full;
   logic              cmd_empty;
   logic              cmd_pop;

   // mode register
   assign gray_mode_in = csr_wr_en ? csr_wr_data : gray_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gray_mode_ff <= 1'b0;
      end else begin
         gray_mode_ff <= gray_mode_in;
      end
   end

   // request handshake
   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   bgts_front #(
      .DIM_BITS (DIM_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .gray_mode (gray_mode_ff),
      .cmd_push  (cmd_push),
      .cmd       (cmd_in)
   );

   bgts_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   bgts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sv/tb_bmp_gray_threshold_stream.sv */
`timescale 1ns / 100ps
// testbench for the bmp gray/threshold stream filter: queued stimulus, predictor and checker
module tb_bmp_gray_threshold_stream;

   localparam int DIM_BITS    = 16;
   localparam int PIXEL_BYTES = 3;
   localparam int ROW_ALIGN   = 4;
   localparam int THRESHOLD   = 128;
   localparam int LIMIT_NS    = 2_000_000;

   typedef enum int {POP_ALWAYS, POP_RANDOM, POP_SLOW, POP_SKIP} pop_pattern_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_push    = 1'b0;
   logic              req_full;
   bgts_pkg::req_type req_data    = '0;
   logic              rsp_empty;
   logic              rsp_pop     = 1'b0;
   bgts_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic              csr_wr_data = 1'b0;

   bmp_gray_threshold_stream #(.DIM_BITS(DIM_BITS)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic                gray_mode;
   logic [31:0]         file_pos;
   logic [31:0]         pix_offset;
   logic [31:0]         dim_scratch;
   logic [DIM_BITS-1:0] img_width;
   logic [DIM_BITS-1:0] img_height;
   logic [DIM_BITS-1:0] rows_done;
   logic [DIM_BITS+1:0] row_pos;
   logic [7:0]          held [2];
   int                  held_count;

   bgts_pkg::rsp_type expected_bytes [$];
   bgts_pkg::req_type pending_bytes [$];
   logic [7:0]        fill_bytes [$];
   int                fail_count = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // magnitude of a signed header dimension, clamped to the dimension range
   function automatic logic [DIM_BITS-1:0] repair_dim(input logic [31:0] raw);
      logic [31:0] mag;
      mag = raw[31] ? -raw : raw;
      if (mag > {DIM_BITS{1'b1}})
         return '1;
      return mag[DIM_BITS-1:0];
   endfunction

   task automatic clear_file_state();
      file_pos    = '0;
      pix_offset  = '0;
      dim_scratch = '0;
      img_width   = '0;
      img_height  = '0;
      rows_done   = '0;
      row_pos     = '0;
      held[0]     = '0;
      held[1]     = '0;
      held_count  = 0;
   endtask

   task automatic store_result(input logic [7:0] b, input logic last_flag,
                               input logic group_flag);
      bgts_pkg::rsp_type r;
      r.byte_out  = b;
      r.last_out  = last_flag;
      r.group_end = group_flag;
      expected_bytes.push_back(r);
   endtask

   // expected output bytes for one accepted file byte
   task automatic filter_byte(input bgts_pkg::req_type r);
      logic [31:0] eff_off;
      logic [31:0] row_data_bytes;
      logic [31:0] row_size;
      logic        in_pixels;
      logic [9:0]  sum;
      logic [7:0]  avg;
      logic [7:0]  v;
      int          k;
      eff_off        = (pix_offset < bgts_pkg::MIN_PIXEL_OFFSET) ? bgts_pkg::MIN_PIXEL_OFFSET
                                                               : pix_offset;
      row_data_bytes = 32'(img_width) * PIXEL_BYTES;
      row_size       = row_data_bytes + (ROW_ALIGN - row_data_bytes % ROW_ALIGN) % ROW_ALIGN;
      in_pixels      = file_pos >= bgts_pkg::MIN_PIXEL_OFFSET && file_pos >= eff_off &&
                       img_width != 0 && rows_done < img_height;

      // header field capture, little endian
      if (file_pos >= bgts_pkg::HDR_OFFSET_POS && file_pos < bgts_pkg::HDR_OFFSET_POS + 4)
         pix_offset |= 32'(r.byte_in) << (8 * (file_pos - bgts_pkg::HDR_OFFSET_POS));
      if (file_pos >= bgts_pkg::HDR_WIDTH_POS && file_pos < bgts_pkg::HDR_HEIGHT_POS + 4) begin
         k = (file_pos - bgts_pkg::HDR_WIDTH_POS) % 4;
         if (k == 0)
            dim_scratch = '0;
         dim_scratch |= 32'(r.byte_in) << (8 * k);
         if (file_pos == bgts_pkg::HDR_WIDTH_POS + 3)
            img_width = repair_dim(dim_scratch);
         if (file_pos == bgts_pkg::HDR_HEIGHT_POS + 3)
            img_height = repair_dim(dim_scratch);
      end

      // pixel triples are held, then released as three equal bytes
      if (in_pixels && row_pos < row_data_bytes) begin
         if (held_count == 2) begin
            sum = 10'(held[0]) + 10'(held[1]) + 10'(r.byte_in);
            avg = 8'(sum / PIXEL_BYTES);
            v   = gray_mode ? avg
                            : ((avg >= THRESHOLD) ? bgts_pkg::WHITE : bgts_pkg::BLACK);
            store_result(v, 1'b0, 1'b0);
            store_result(v, 1'b0, 1'b0);
            store_result(v, r.last_in, 1'b1);
            held_count = 0;
         end else if (!r.last_in) begin
            held[held_count] = r.byte_in;
            held_count++;
         end else begin
            // file ends inside a triple: release what is held unchanged
            for (int i = 0; i < held_count; i++)
               store_result(held[i], 1'b0, 1'b0);
            store_result(r.byte_in, 1'b1, 1'b1);
            held_count = 0;
         end
      end else begin
         store_result(r.byte_in, r.last_in, 1'b1);
      end

      // row and position bookkeeping
      if (in_pixels) begin
         row_pos++;
         if (row_pos >= row_size) begin
            row_pos = '0;
            rows_done++;
         end
      end
      if (file_pos != '1)
         file_pos++;
      if (r.last_in)
         clear_file_state();
   endtask

   // queue one file: random bytes, header fields placed, pixel area from fill_bytes first
   task automatic add_file(input logic [31:0] offset, input logic [31:0] width,
                           input logic [31:0] height, input int len);
      bgts_pkg::req_type r;
      logic [7:0]        b;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i >= bgts_pkg::HDR_OFFSET_POS && i < bgts_pkg::HDR_OFFSET_POS + 4)
            b = offset[8*(i-bgts_pkg::HDR_OFFSET_POS) +: 8];
         else if (i >= bgts_pkg::HDR_WIDTH_POS && i < bgts_pkg::HDR_WIDTH_POS + 4)
            b = width[8*(i-bgts_pkg::HDR_WIDTH_POS) +: 8];
         else if (i >= bgts_pkg::HDR_HEIGHT_POS && i < bgts_pkg::HDR_HEIGHT_POS + 4)
            b = height[8*(i-bgts_pkg::HDR_HEIGHT_POS) +: 8];
         else if (i >= bgts_pkg::MIN_PIXEL_OFFSET && fill_bytes.size() > 0)
            b = fill_bytes.pop_front();
         r.byte_in = b;
         r.last_in = (i == len - 1);
         pending_bytes.push_back(r);
      end
   endtask

   task automatic write_gray_mode(input logic mode);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gray_mode    = mode;
   endtask

   // wait until every request is taken and every result has come back
   task automatic drain();
      while (pending_bytes.size() != 0 || req_push || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // request driver: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            filter_byte(req_data);
            void'(pending_bytes.pop_front());
         end
         if (!(req_push && req_full)) begin
            if (gap_left > 0 || pending_bytes.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_push <= 1'b0;
            end else begin
               req_push <= 1'b1;
               req_data <= pending_bytes[0];
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // result monitor: pop pattern is redrawn at random, results are checked in order
   pop_pattern_type   pop_pattern = POP_ALWAYS;
   int                pop_cycle   = 0;
   bgts_pkg::rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: byte_out %0h last_out %0b", rsp_data.byte_out,
                      rsp_data.last_out);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.byte_out !== want.byte_out) begin
                  $error("byte_out: expected %0h, got %0h", want.byte_out, rsp_data.byte_out);
                  fail_count++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_data.last_out);
                  fail_count++;
               end
               if (rsp_data.group_end !== want.group_end) begin
                  $error("group_end: expected %0b, got %0b", want.group_end,
                         rsp_data.group_end);
                  fail_count++;
               end
            end
         end
         pop_cycle++;
         if (pop_cycle % 40 == 0)
            pop_pattern = pop_pattern_type'($urandom_range(0, 3));
         case (pop_pattern)
            POP_ALWAYS: rsp_pop <= 1'b1;
            POP_RANDOM: rsp_pop <= 1'($urandom_range(0, 1));
            POP_SLOW:   rsp_pop <= (pop_cycle % 7) < 2;
            default:    rsp_pop <= (pop_cycle % 3) != 0;
         endcase
      end
   end

   // run limit
   initial begin
      #(LIMIT_NS);
      $display("tb_bmp_gray_threshold_stream: FAIL");
      $finish;
   end

   // stimulus sequence
   initial begin
      clear_file_state();
      gray_mode = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // threshold mode, directed files
      write_gray_mode(1'b0);
      // one-byte file, and a file cut off inside the header
      add_file(bgts_pkg::MIN_PIXEL_OFFSET, 1, 1, 1);
      add_file(bgts_pkg::MIN_PIXEL_OFFSET, 2, 2, 12);
      // width 1 rows with padding, threshold edges, trailing bytes
      fill_bytes = '{8'd0, 8'd0, 8'd0, 8'($urandom),
                     8'd127, 8'd128, 8'd127, 8'($urandom),
                     8'd128, 8'd128, 8'd128, 8'($urandom)};
      add_file(bgts_pkg::MIN_PIXEL_OFFSET, 1, 3, 40);
      // small offset, oversize and negative dimensions clamp, file ends with one byte held
      fill_bytes = '{8'd10, 8'd20, 8'd30};
      add_file(0, 32'h0001_2345, 32'h8000_0000, 31);
      drain();

      // grayscale mode, negative width, trailing bytes
      write_gray_mode(1'b1);
      fill_bytes = '{8'd255, 8'd255, 8'd255, 8'($urandom),
                     8'd255, 8'd254, 8'd253, 8'($urandom),
                     8'd0, 8'd1, 8'd1, 8'($urandom)};
      add_file(bgts_pkg::MIN_PIXEL_OFFSET, 32'hffff_ffff, 3, 40);
      drain();

      if (fail_count == 0)
         $display("tb_bmp_gray_threshold_stream: PASS");
      else
         $display("tb_bmp_gray_threshold_stream: FAIL");
      $finish;
   end

endmodule
